// ===== design/lcag_pkg.sv =====
// lcag_pkg: shared types and constants for the life cellular automaton grid core
// used by the row cell, the top level and the port checker; no dependencies

package lcag_pkg;

  // word kinds on the input channel
  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_ADVANCE = 2'd1,
    KIND_READ    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_ACTIVE_ROWS = 1'b0,
    REG_ACTIVE_COLS = 1'b1
  } reg_idx_e;

  // field widths
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned ACTIVE_W = 6;
  // compare width wide enough for any grid index and any register value
  localparam int unsigned AREA_W   = 9;
  // neighbour count width
  localparam int unsigned NBR_W    = 4;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET  = 6'd20;
  localparam logic [NBR_W-1:0]    BIRTH_COUNT   = 4'd3;
  localparam logic [NBR_W-1:0]    SURVIVE_COUNT = 4'd2;

  // control broadcast from the top level to every row cell
  typedef struct packed {
    logic              accept;
    kind_e             kind;
    logic [ADDR_W-1:0] row;
    logic [ADDR_W-1:0] col;
    logic              cell_in;
  } cell_ctrl_t;

endpackage

// ===== design/lcag_row_cell.sv =====
// lcag_row_cell: one grid row, its life update and its share of write and read
// depends on lcag_pkg; neighbours are the rows above and below in the chain

module lcag_row_cell #(
  parameter int unsigned MAX_COLS = 32,
  parameter int unsigned ROW_IDX  = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lcag_pkg::cell_ctrl_t          ctrl_i,
  input  logic [lcag_pkg::AREA_W-1:0]   active_rows_i,
  input  logic [MAX_COLS-1:0]           col_mask_i,
  input  logic [MAX_COLS-1:0]           above_i,
  input  logic [MAX_COLS-1:0]           below_i,
  output logic [MAX_COLS-1:0]           row_o,
  output logic                          rd_bit_o
);
  import lcag_pkg::*;

  logic [MAX_COLS-1:0] row_q, row_d;
  logic                rd_bit_q, rd_bit_d;
  logic                row_act, row_hit;
  logic [MAX_COLS-1:0] col_sel, wr_sel, life_next;
  logic [MAX_COLS+1:0] up_p, own_p, dn_p;

  // row in the active area and addressed by the word
  assign row_act = AREA_W'(ROW_IDX) < active_rows_i;
  assign row_hit = row_act && (AREA_W'(ctrl_i.row) == AREA_W'(ROW_IDX));

  // masked row handed to both neighbours: inactive cells read as dead
  assign row_o = row_q & col_mask_i & {MAX_COLS{row_act}};

  // zero padding at the left and right edges
  assign up_p  = {1'b0, above_i, 1'b0};
  assign own_p = {1'b0, row_o, 1'b0};
  assign dn_p  = {1'b0, below_i, 1'b0};

  // per column neighbour count and b3/s23 rule
  for (genvar j = 0; j < MAX_COLS; j++) begin : g_col
    logic [NBR_W-1:0] cnt;
    assign cnt = NBR_W'(up_p[j]) + NBR_W'(up_p[j+1]) + NBR_W'(up_p[j+2])
               + NBR_W'(own_p[j]) + NBR_W'(own_p[j+2])
               + NBR_W'(dn_p[j]) + NBR_W'(dn_p[j+1]) + NBR_W'(dn_p[j+2]);
    assign life_next[j] = (cnt == BIRTH_COUNT) || ((cnt == SURVIVE_COUNT) && row_o[j]);
    assign col_sel[j]   = AREA_W'(ctrl_i.col) == AREA_W'(j);
  end

  assign wr_sel = col_sel & col_mask_i & {MAX_COLS{row_hit}};

  // row update per word kind
  always_comb begin
    row_d    = row_q;
    rd_bit_d = rd_bit_q;
    if (ctrl_i.accept) begin
      rd_bit_d = 1'b0;
      unique case (ctrl_i.kind)
        KIND_WRITE: begin
          row_d = (row_q & ~wr_sel) | (wr_sel & {MAX_COLS{ctrl_i.cell_in}});
        end
        KIND_ADVANCE: begin
          row_d = life_next & col_mask_i & {MAX_COLS{row_act}};
        end
        KIND_READ: begin
          rd_bit_d = row_hit && (|(row_q & col_sel & col_mask_i));
        end
        default: begin
          row_d = row_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= '0;
      rd_bit_q <= 1'b0;
    end else begin
      row_q    <= row_d;
      rd_bit_q <= rd_bit_d;
    end
  end

  assign rd_bit_o = rd_bit_q;

endmodule

// ===== design/life_cellular_automaton_grid_core.sv =====
// life_cellular_automaton_grid_core: top level, chain of row cells and word handling
// depends on lcag_pkg and lcag_row_cell

// Grid of MAX_ROWS x MAX_COLS one-bit cells running Conway's Life (B3/S23).
// Each word writes a cell, reads a cell, is a no-op or advances one generation of the
// whole grid; each word gives exactly one result word. Rows are held in a chain
// of row cells that each see the rows of their neighbours combinationally, so an
// advance, a write or a read all take effect at the edge where the word is
// accepted. The result then passes through one pending stage, where the read
// bits of all row cells are OR-ed together, into the output register; the block
// accepts the next word while the previous result waits in the output register.
// Cells outside active_rows x active_cols count as dead, read as 0 and are cleared
// by an advance. Reset clears the grid at once; there is no clearing pass.
// Configuration must be written only while idle; the block does not enforce it.

module life_cellular_automaton_grid_core #(
  parameter int unsigned MAX_ROWS = 32,
  parameter int unsigned MAX_COLS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [lcag_pkg::ACTIVE_W-1:0] cfg_wdata_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    kind_i,
  input  logic [lcag_pkg::ADDR_W-1:0]   row_i,
  input  logic [lcag_pkg::ADDR_W-1:0]   col_i,
  input  logic                          cell_in_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          cell_out_o,
  output logic                          generation_done_o
);
  import lcag_pkg::*;

  logic [ACTIVE_W-1:0] active_rows_q, active_cols_q;
  logic                pend_q, pend_d;
  kind_e               pend_kind_q, pend_kind_d;
  logic                out_valid_q, out_valid_d;
  logic                cell_out_q, cell_out_d;
  logic                gen_done_q, gen_done_d;
  logic                in_accept, pend_move;
  cell_ctrl_t          ctrl;
  logic [MAX_COLS-1:0] col_mask;
  logic [MAX_COLS-1:0] rows_m [MAX_ROWS];
  logic [MAX_ROWS-1:0] rd_bits;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_rows_q <= ACTIVE_RESET;
      active_cols_q <= ACTIVE_RESET;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_ACTIVE_ROWS: active_rows_q <= cfg_wdata_i;
        REG_ACTIVE_COLS: active_cols_q <= cfg_wdata_i;
        default:         active_rows_q <= active_rows_q;
      endcase
    end
  end

  // active column mask
  for (genvar j = 0; j < MAX_COLS; j++) begin : g_mask
    assign col_mask[j] = AREA_W'(j) < AREA_W'(active_cols_q);
  end

  // control word broadcast to the chain
  assign in_accept    = in_valid_i && !pend_q;
  assign ctrl.accept  = in_accept;
  assign ctrl.kind    = kind_e'(kind_i);
  assign ctrl.row     = row_i;
  assign ctrl.col     = col_i;
  assign ctrl.cell_in = cell_in_i;

  // chain of row cells, dead rows beyond both ends
  for (genvar r = 0; r < MAX_ROWS; r++) begin : g_row
    logic [MAX_COLS-1:0] above, below;
    if (r == 0) begin : g_top
      assign above = '0;
    end else begin : g_top
      assign above = rows_m[r-1];
    end
    if (r == MAX_ROWS - 1) begin : g_bot
      assign below = '0;
    end else begin : g_bot
      assign below = rows_m[r+1];
    end

    lcag_row_cell #(
      .MAX_COLS (MAX_COLS),
      .ROW_IDX  (r)
    ) u_row (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .active_rows_i (AREA_W'(active_rows_q)),
      .col_mask_i    (col_mask),
      .above_i       (above),
      .below_i       (below),
      .row_o         (rows_m[r]),
      .rd_bit_o      (rd_bits[r])
    );
  end

  // pending stage and output register
  assign pend_move = pend_q && (!out_valid_q || !out_stall_i);

  always_comb begin
    pend_d      = pend_q;
    pend_kind_d = pend_kind_q;
    out_valid_d = out_valid_q;
    cell_out_d  = cell_out_q;
    gen_done_d  = gen_done_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (pend_move) begin
      pend_d      = 1'b0;
      out_valid_d = 1'b1;
      cell_out_d  = (pend_kind_q == KIND_READ) && (|rd_bits);
      gen_done_d  = pend_kind_q == KIND_ADVANCE;
    end
    if (in_accept) begin
      pend_d      = 1'b1;
      pend_kind_d = ctrl.kind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_kind_q <= pend_kind_d;
    cell_out_q  <= cell_out_d;
    gen_done_q  <= gen_done_d;
  end

  assign in_stall_o        = pend_q;
  assign out_valid_o       = out_valid_q;
  assign cell_out_o        = cell_out_q;
  assign generation_done_o = gen_done_q;

endmodule

// ===== design/lcag_checker.sv =====
// lcag_checker: port level assertions for the life grid core
// depends on lcag_pkg; bound to life_cellular_automaton_grid_core below

module lcag_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [1:0]                    kind_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          cell_out_o,
  input logic                          generation_done_o
);
  import lcag_pkg::*;

  // a stalled result word stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // a result is a read bit or a generation mark, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(cell_out_o && generation_done_o))
    else $error("read bit and generation mark both set");

  // one word at a time: an accepted word stalls the input next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after an accepted word");

  // an accepted advance with the output empty yields a generation mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (kind_i == KIND_ADVANCE) && !out_valid_o
    |=> ##1 out_valid_o && generation_done_o)
    else $error("advance gave no generation mark");

endmodule

bind life_cellular_automaton_grid_core lcag_checker u_lcag_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .kind_i            (kind_i),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .cell_out_o        (cell_out_o),
  .generation_done_o (generation_done_o)
);
